// ===== rtl/wfps_pkg.sv =====
// Shared types and constants for the wall-following PID steering block.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package wfps_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_KP_GAIN     = 3'd0;
    localparam logic [2:0] REG_KI_GAIN     = 3'd1;
    localparam logic [2:0] REG_KD_PER_TICK = 3'd2;
    localparam logic [2:0] REG_INT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_BASE_SPEED  = 3'd4;
    localparam logic [2:0] REG_CAR_WIDTH   = 3'd5;
    localparam logic [2:0] REG_NEAR_WALL   = 3'd6;

    // Radix-16 divide-by-five steps over the 28-bit filter numerator
    localparam int DIV_STEPS = 7;

    // Signed width that holds any correction or speed up to 65535
    localparam int CORR_W = 18;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_FILT,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_SUM,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MUL_KP,
        MUL_KI,
        MUL_KD
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     calc_err;
        logic     div_step;
        logic     filt_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_add;
        logic     acc_shift;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== rtl/wfps_ctrl.sv =====
// Sequencer for one steering tick: error, divide, filter load, three multiplies, sum, finish.
// Depends on wfps_pkg.
`timescale 1ns / 1ps

module wfps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wfps_pkg::status_t status,
    output wfps_pkg::cmd_t    cmd
);

    localparam logic [2:0] LAST_STEP = 3'(wfps_pkg::DIV_STEPS - 1);

    wfps_pkg::state_t state_reg;
    wfps_pkg::state_t state_next;
    logic [2:0]       cnt_reg;
    logic [2:0]       cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfps_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            wfps_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = wfps_pkg::ST_ERR;
                end
            end
            wfps_pkg::ST_ERR:
            begin
                cnt_next   = '0;
                state_next = wfps_pkg::ST_DIV;
            end
            wfps_pkg::ST_DIV:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = wfps_pkg::ST_FILT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            wfps_pkg::ST_FILT: state_next = wfps_pkg::ST_MP;
            wfps_pkg::ST_MP:   state_next = wfps_pkg::ST_MI;
            wfps_pkg::ST_MI:   state_next = wfps_pkg::ST_MD;
            wfps_pkg::ST_MD:   state_next = wfps_pkg::ST_SUM;
            wfps_pkg::ST_SUM:  state_next = wfps_pkg::ST_FIN;
            wfps_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = wfps_pkg::ST_IDLE;
                end
            end
            default: state_next = wfps_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            wfps_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            wfps_pkg::ST_ERR:  cmd.calc_err  = 1'b1;
            wfps_pkg::ST_DIV:  cmd.div_step  = 1'b1;
            wfps_pkg::ST_FILT: cmd.filt_load = 1'b1;
            wfps_pkg::ST_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = wfps_pkg::MUL_KP;
                cmd.acc_clr = 1'b1;
            end
            wfps_pkg::ST_MI:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = wfps_pkg::MUL_KI;
                cmd.acc_add   = 1'b1;
                cmd.acc_shift = 1'b1;
            end
            wfps_pkg::ST_MD:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = wfps_pkg::MUL_KD;
                cmd.acc_add   = 1'b1;
                cmd.acc_shift = 1'b1;
            end
            wfps_pkg::ST_SUM:  cmd.acc_add  = 1'b1;
            wfps_pkg::ST_FIN:  cmd.out_load = status.out_free;
            default:           cmd          = '0;
        endcase
    end

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfps_pkg::ST_FIN && !status.out_free) |=>
        (state_reg == wfps_pkg::ST_FIN))
        else $error("finish state left while output register busy");

    a_accept_err: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (state_reg == wfps_pkg::ST_ERR))
        else $error("accepted beat not followed by error stage");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfps_pkg::ST_DIV && cnt_reg == LAST_STEP) |=>
        (state_reg == wfps_pkg::ST_FILT))
        else $error("divide sequence did not end after last step");

endmodule

// ===== rtl/wfps_datapath.sv =====
// Datapath: configuration registers, error/integral logic, divide-by-five
// filter unit, shared multiplier, Q40.32 accumulator, output register. Uses wfps_pkg.
`timescale 1ns / 1ps

module wfps_datapath #(
    parameter int MAX_OUTPUT = 1000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    input  logic              cfg_wr,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  wfps_pkg::cmd_t    cmd,
    output wfps_pkg::status_t status
);

    localparam int CW = wfps_pkg::CORR_W;
    localparam logic signed [40:0] MAX_Q = 41'(MAX_OUTPUT);
    localparam logic signed [CW+1:0] MAX_S = (CW+2)'(MAX_OUTPUT);
    localparam logic signed [25:0] FILT_BOUND = 26'sd16711680;

    // Configuration
    logic [31:0] kp_gain_reg;
    logic [31:0] ki_gain_reg;
    logic [31:0] kd_per_tick_reg;
    logic [19:0] integral_limit_reg;
    logic [9:0]  base_speed_reg;
    logic [6:0]  car_width_reg;
    logic [7:0]  near_wall_reg;

    // Controller state
    logic signed [20:0] error_sum_reg;
    logic signed [7:0]  last_error_reg;
    logic signed [25:0] filt_reg;

    // Per-tick work registers
    logic [7:0]         left_reg;
    logic [7:0]         right_reg;
    logic signed [7:0]  e_reg;
    logic signed [20:0] acc_reg;
    logic               near_reg;
    logic [27:0]        div_reg;
    logic [2:0]         rem_reg;
    logic               neg_reg;
    logic signed [58:0] prod_reg;
    logic signed [71:0] total_reg;

    logic        out_valid_reg;
    logic [10:0] corr_out_reg;
    logic [9:0]  left_out_reg;
    logic [9:0]  right_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg        <= 32'd983040;
            ki_gain_reg        <= 32'd655;
            kd_per_tick_reg    <= 32'd66;
            integral_limit_reg <= 20'd50000;
            base_speed_reg     <= 10'd900;
            car_width_reg      <= 7'd16;
            near_wall_reg      <= 8'd5;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                wfps_pkg::REG_KP_GAIN:     kp_gain_reg        <= cfg_data;
                wfps_pkg::REG_KI_GAIN:     ki_gain_reg        <= cfg_data;
                wfps_pkg::REG_KD_PER_TICK: kd_per_tick_reg    <= cfg_data;
                wfps_pkg::REG_INT_LIMIT:   integral_limit_reg <= cfg_data[19:0];
                wfps_pkg::REG_BASE_SPEED:  base_speed_reg     <= cfg_data[9:0];
                wfps_pkg::REG_CAR_WIDTH:   car_width_reg      <= cfg_data[6:0];
                wfps_pkg::REG_NEAR_WALL:   near_wall_reg      <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    // Position error, integral clamp and filter numerator
    logic [9:0]         width_sum;
    logic signed [10:0] e_raw;
    logic signed [7:0]  e_sat;
    logic signed [21:0] acc_raw;
    logic signed [21:0] lim_s;
    logic signed [20:0] acc_cl;
    logic signed [9:0]  diff;
    logic signed [27:0] num;
    logic [27:0]        num_mag;

    always_comb
    begin
        width_sum = {2'b00, left_reg} + {2'b00, right_reg} + {3'b000, car_width_reg};
        e_raw = $signed({3'b000, left_reg}) + $signed({5'b00000, car_width_reg[6:1]})
              - $signed({2'b00, width_sum[9:1]});
        if (e_raw > 11'sd127)
        begin
            e_sat = 8'sd127;
        end
        else if (e_raw < -11'sd128)
        begin
            e_sat = -8'sd128;
        end
        else
        begin
            e_sat = e_raw[7:0];
        end

        acc_raw = {error_sum_reg[20], error_sum_reg} + {{14{e_sat[7]}}, e_sat};
        lim_s   = $signed({2'b00, integral_limit_reg});
        if (acc_raw > lim_s)
        begin
            acc_cl = lim_s[20:0];
        end
        else if (acc_raw < -lim_s)
        begin
            acc_cl = 21'(-lim_s);
        end
        else
        begin
            acc_cl = acc_raw[20:0];
        end

        diff    = {{2{e_sat[7]}}, e_sat} - {{2{last_error_reg[7]}}, last_error_reg};
        num     = $signed({filt_reg, 2'b00}) + $signed({{2{diff[9]}}, diff, 16'h0000});
        num_mag = num[27] ? 28'(-num) : num;
    end

    // One radix-16 digit of the divide by five
    logic [6:0]  dv;
    logic [14:0] dv_scaled;
    logic [3:0]  qd;
    logic [6:0]  dv_rem;

    always_comb
    begin
        dv        = {rem_reg, div_reg[27:24]};
        dv_scaled = {8'h00, dv} * 15'd205;
        qd        = dv_scaled[13:10];
        dv_rem    = dv - {1'b0, qd, 2'b00} - {3'b000, qd};
    end

    // Shared multiplier
    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [58:0] prod_next;

    always_comb
    begin
        unique case (cmd.mul_sel)
            wfps_pkg::MUL_KP:
            begin
                mul_a = $signed({1'b0, kp_gain_reg});
                mul_b = {{18{e_reg[7]}}, e_reg};
            end
            wfps_pkg::MUL_KI:
            begin
                mul_a = $signed({1'b0, ki_gain_reg});
                mul_b = {{5{acc_reg[20]}}, acc_reg};
            end
            wfps_pkg::MUL_KD:
            begin
                mul_a = $signed({1'b0, kd_per_tick_reg});
                mul_b = filt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    logic signed [71:0] prod_ext;
    logic signed [71:0] addend;

    always_comb
    begin
        prod_ext = {{13{prod_reg[58]}}, prod_reg};
        addend   = cmd.acc_shift ? {prod_ext[55:0], 16'h0000} : prod_ext;
    end

    // Truncate toward zero, clamp, form speeds
    logic signed [39:0]   q_floor;
    logic                 frac_nz;
    logic signed [40:0]   q_trunc;
    logic signed [CW-1:0] corr;
    logic signed [CW+1:0] ls_raw;
    logic signed [CW+1:0] rs_raw;
    logic signed [CW+1:0] ls_cl;
    logic signed [CW+1:0] rs_cl;

    always_comb
    begin
        q_floor = total_reg[71:32];
        frac_nz = |total_reg[31:0];
        q_trunc = {q_floor[39], q_floor} + {40'd0, total_reg[71] & frac_nz};
        if (q_trunc > MAX_Q)
        begin
            corr = CW'(MAX_OUTPUT);
        end
        else if (q_trunc < -MAX_Q)
        begin
            corr = CW'(-MAX_Q);
        end
        else
        begin
            corr = q_trunc[CW-1:0];
        end

        ls_raw = $signed({{(CW-8){1'b0}}, base_speed_reg}) - {{2{corr[CW-1]}}, corr};
        rs_raw = $signed({{(CW-8){1'b0}}, base_speed_reg}) + {{2{corr[CW-1]}}, corr};
        ls_cl  = (ls_raw < 0) ? '0 : ((ls_raw > MAX_S) ? MAX_S : ls_raw);
        rs_cl  = (rs_raw < 0) ? '0 : ((rs_raw > MAX_S) ? MAX_S : rs_raw);
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            left_reg  <= s_tdata[7:0];
            right_reg <= s_tdata[15:8];
        end
        if (cmd.calc_err)
        begin
            e_reg    <= e_sat;
            acc_reg  <= acc_cl;
            near_reg <= (left_reg < near_wall_reg) || (right_reg < near_wall_reg);
            div_reg  <= num_mag;
            rem_reg  <= 3'd0;
            neg_reg  <= num[27];
        end
        if (cmd.div_step)
        begin
            div_reg <= {div_reg[23:0], qd};
            rem_reg <= dv_rem[2:0];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_clr)
        begin
            total_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            total_reg <= total_reg + addend;
        end
        if (cmd.out_load)
        begin
            corr_out_reg  <= corr[10:0];
            left_out_reg  <= ls_cl[9:0];
            right_out_reg <= rs_cl[9:0];
        end
    end

    // Tick-to-tick state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            filt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.filt_load)
            begin
                filt_reg <= neg_reg ? 26'(-$signed(div_reg[25:0])) : $signed(div_reg[25:0]);
            end
            if (cmd.out_load)
            begin
                error_sum_reg  <= near_reg ? '0 : acc_reg;
                last_error_reg <= near_reg ? '0 : e_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {1'b0, right_out_reg, left_out_reg, corr_out_reg};

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < 3'd5))
        else $error("divide remainder out of range");

    a_filt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (filt_reg <= FILT_BOUND) && (filt_reg >= -FILT_BOUND))
        else $error("filtered difference beyond its bound");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== rtl/wall_following_pid_steering.sv =====
// Top level of the wall-following PID steering block.
// Instantiates wfps_ctrl and wfps_datapath; types come from wfps_pkg.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata[15:0]: left_distance, right_distance
// m_        out  m_tvalid/m_tready    m_tdata[31:0]: correction, left drive, right drive
// cfg_      in   cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[31:0]
//
// Sequence: an accepted beat passes the error step, the seven radix-16 steps of
//   the divide-by-five filter unit, the filter load, three passes through the
//   single shared 33x26 multiplier, a sum and the finish step into the output
//   register; the next beat is taken only once the sequencer is idle again.
// Reset: rst_n clears the sequencer, integral, previous error, filter state and
//   output valid, and loads the register defaults; no clearing pass.
// Stalls: a held result sits in the output register; the next beat is accepted
//   and processed meanwhile, and the sequencer waits in its final step only if
//   the earlier result is still untaken.
// Configuration is always ready; write only while no tick is in flight.

module wall_following_pid_steering #(
    parameter int MAX_OUTPUT = 1000
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] left_distance, [15:8] right_distance
    // Result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] correction (signed), [20:11] left drive,
                                   // [30:21] right drive, [31] zero
    // Register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    wfps_pkg::cmd_t    cmd;
    wfps_pkg::status_t status;

    // Registers accept a write every cycle
    assign cfg_ready = 1'b1;

    wfps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wfps_datapath #(
        .MAX_OUTPUT (MAX_OUTPUT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
